// ===== rtl/raised_cosine_crossfader_core_assert.svh =====
// Assertion macros shared by the crossfader checker.
// Each macro expects clk and rst_n in scope.
`ifndef RAISED_COSINE_CROSSFADER_CORE_ASSERT_SVH
`define RAISED_COSINE_CROSSFADER_CORE_ASSERT_SVH

// Same-cycle implication
`define CRF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crossfader check failed: same-cycle implication");

// Next-cycle implication
`define CRF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crossfader check failed: next-cycle implication");

`endif

// ===== rtl/crf_pkg.sv =====
`default_nettype none

package crf_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COS_TABLE_SIZE_DEF = 1024;
  localparam int MAX_CHANNELS_DEF   = 8;

  // Register and field widths
  localparam int LEN_W      = 24;
  localparam int CHAN_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);

  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);

  // Weight format: Q1.16, 0..65536
  localparam int            W_FRAC = 16;
  localparam int            W_W    = 17;
  localparam logic [W_W-1:0] W_ONE = W_W'(65536);

  // Cosine table generation: pi/2 in Q30 and Taylor divisors (2k)(2k+1)
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam int              TAYLOR_TERMS = 14;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;

  // Per-word control bits passed from front to back
  typedef struct packed {
    logic first;
    logic fading;
    logic last;
  } crf_ctrl_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROM,
    BK_MUL,
    BK_ACC
  } crf_state_t;

endpackage

`default_nettype wire

// ===== rtl/crf_front.sv =====
`default_nettype none

module crf_front #(
  parameter int SAMPLE_BITS  = crf_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = crf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_old_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_new_sample,
  input  logic                                in_start_fade,
  input  logic [crf_pkg::LEN_W-1:0]           fade_length,
  input  logic [crf_pkg::CHAN_W-1:0]          channel_count,
  output logic                                push,
  output logic [2*SAMPLE_BITS+crf_pkg::LEN_W+$bits(crf_pkg::crf_ctrl_t)-1:0] push_data,
  input  logic                                q_full
);
  import crf_pkg::*;

  localparam int SLOT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW     = CHAN_W + 1;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              frame_fading_r, frame_fading_nxt;

  logic              accept;
  logic              first;
  logic              last;
  logic              in_range;
  logic              fading_now;
  logic [LEN_W-1:0]  pos_eff;
  logic [CW-1:0]     chans_eff;
  crf_ctrl_t         ctrl;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  // Channel count clamp: zero acts as one, large values as the maximum
  always_comb begin
    if (channel_count == '0) begin
      chans_eff = CW'(1);
    end else if (CW'(channel_count) > CW'(MAX_CHANNELS)) begin
      chans_eff = CW'(MAX_CHANNELS);
    end else begin
      chans_eff = CW'(channel_count);
    end
  end

  // Classify the word within its frame
  always_comb begin
    first      = (slot_r == '0);
    pos_eff    = (first && in_start_fade) ? '0 : pos_r;
    in_range   = (fade_length != '0) && (pos_eff < fade_length);
    fading_now = first ? in_range : frame_fading_r;
    last       = (CW'(slot_r) + CW'(1)) >= chans_eff;
    ctrl.first  = first;
    ctrl.fading = fading_now;
    ctrl.last   = last;
  end

  assign push_data = {in_old_sample, in_new_sample, pos_eff, ctrl};

  // Frame position bookkeeping
  always_comb begin
    slot_nxt         = slot_r;
    pos_nxt          = pos_r;
    frame_fading_nxt = frame_fading_r;
    if (accept) begin
      if (first) begin
        frame_fading_nxt = fading_now;
      end
      pos_nxt = pos_eff;
      if (last) begin
        slot_nxt = '0;
        if (in_range) begin
          pos_nxt = pos_eff + LEN_W'(1);
        end
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r         <= '0;
      pos_r          <= '0;
      frame_fading_r <= 1'b0;
    end else begin
      slot_r         <= slot_nxt;
      pos_r          <= pos_nxt;
      frame_fading_r <= frame_fading_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crf_queue.sv =====
`default_nettype none

module crf_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output logic [DATA_W-1:0] rd_data
);
  import crf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crf_back.sv =====
`default_nettype none

module crf_back #(
  parameter int SAMPLE_BITS    = crf_pkg::SAMPLE_BITS_DEF,
  parameter int COS_TABLE_SIZE = crf_pkg::COS_TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [2*SAMPLE_BITS+crf_pkg::LEN_W+$bits(crf_pkg::crf_ctrl_t)-1:0] q_data,
  output logic                          q_pop,
  input  logic [crf_pkg::LEN_W-1:0]     fade_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_mixed_sample,
  output logic                          out_fading,
  output logic                          out_frame_end
);
  import crf_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CTRL_W = $bits(crf_ctrl_t);
  localparam int IDX_W  = $clog2(COS_TABLE_SIZE);
  localparam int NUM_W  = LEN_W + IDX_W;
  localparam int CNT_W  = $clog2(IDX_W);
  localparam int ACC_W  = SB + 18;

  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (W_FRAC - 1);
  localparam logic signed [SB+1:0]    SAT_HI  = {3'b000, {(SB-1){1'b1}}};
  localparam logic signed [SB+1:0]    SAT_LO  = {3'b111, {(SB-1){1'b0}}};

  // One ROM entry: round(65536 * sin((pi/2) * idx / size)^2), sine by Taylor series in Q30
  function automatic logic [W_W-1:0] rom_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned w;
    longint          sum;
    x    = (HALF_PI_Q30 * 64'(idx)) / 64'(COS_TABLE_SIZE);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[k-1];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = longint'(sum);
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    w = (s * s + (64'd1 << 43)) >> 44;
    if (w > 64'(W_ONE)) begin
      w = 64'(W_ONE);
    end
    return W_W'(w);
  endfunction

  // Cosine weight table
  logic [W_W-1:0] rom_w [COS_TABLE_SIZE];
  for (genvar g = 0; g < COS_TABLE_SIZE; g++) begin : g_rom
    localparam logic [W_W-1:0] ENTRY = rom_entry(g);
    assign rom_w[g] = ENTRY;
  end

  // Queue word fields
  crf_ctrl_t                q_ctrl;
  logic [LEN_W-1:0]         q_pos;
  logic signed [SB-1:0]     q_new;
  logic signed [SB-1:0]     q_old;
  logic [NUM_W-1:0]         q_num;

  assign q_ctrl = crf_ctrl_t'(q_data[CTRL_W-1:0]);
  assign q_pos  = q_data[CTRL_W +: LEN_W];
  assign q_new  = q_data[CTRL_W+LEN_W +: SB];
  assign q_old  = q_data[CTRL_W+LEN_W+SB +: SB];
  assign q_num  = NUM_W'(q_pos) * NUM_W'(COS_TABLE_SIZE);

  crf_state_t state_r, state_nxt;

  logic signed [SB-1:0]    old_r;
  logic signed [SB-1:0]    new_r;
  logic                    fading_r;
  logic                    last_r;
  logic [W_W-1:0]          weight_r;
  logic [LEN_W-1:0]        rem_r;
  logic [IDX_W-1:0]        nlow_r;
  logic [IDX_W-1:0]        quo_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [ACC_W-1:0] prod_r;

  logic                    out_valid_r;
  logic signed [SB-1:0]    out_mixed_r;
  logic                    out_fading_r;
  logic                    out_end_r;

  logic div_en;
  logic rom_en;
  logic mul_en;
  logic out_load;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_ctrl.first && q_ctrl.fading) ? BK_DIV : BK_MUL;
        end
      end
      BK_DIV: begin
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          state_nxt = BK_ROM;
        end
      end
      BK_ROM: state_nxt = BK_MUL;
      BK_MUL: state_nxt = BK_ACC;
      BK_ACC: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    div_en   = 1'b0;
    rom_en   = 1'b0;
    mul_en   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_DIV:  div_en   = 1'b1;
      BK_ROM:  rom_en   = 1'b1;
      BK_MUL:  mul_en   = 1'b1;
      BK_ACC:  out_load = out_free;
      default: q_pop    = 1'b0;
    endcase
  end

  // Restoring divider step: index = pos * size / length, one quotient bit per cycle
  logic [LEN_W:0]   rem2;
  logic             rem_ge;
  logic [LEN_W-1:0] rem_nxt;

  always_comb begin
    rem2    = {rem_r, nlow_r[IDX_W-1]};
    rem_ge  = (rem2 >= {1'b0, fade_length});
    rem_nxt = rem_ge ? LEN_W'(rem2 - {1'b0, fade_length}) : LEN_W'(rem2);
  end

  // Blend: old * 65536 + (new - old) * w
  logic signed [SB:0]      diff;
  logic signed [W_W:0]     w_sig;
  logic signed [SB+18:0]   mul_full;
  logic signed [ACC_W-1:0] old_ext;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [SB+1:0]    acc_shift;
  logic signed [SB-1:0]    mixed;

  always_comb begin
    diff     = $signed({new_r[SB-1], new_r}) - $signed({old_r[SB-1], old_r});
    w_sig    = $signed({1'b0, weight_r});
    mul_full = diff * w_sig;
    old_ext  = ACC_W'(old_r);
    acc_sum  = (old_ext <<< W_FRAC) + prod_r + ROUND_C;
    acc_shift = acc_sum[ACC_W-1:W_FRAC];
    if (acc_shift > SAT_HI) begin
      mixed = SAT_HI[SB-1:0];
    end else if (acc_shift < SAT_LO) begin
      mixed = SAT_LO[SB-1:0];
    end else begin
      mixed = acc_shift[SB-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_r    <= q_old;
      new_r    <= q_new;
      fading_r <= q_ctrl.fading;
      last_r   <= q_ctrl.last;
      if (q_ctrl.first) begin
        if (q_ctrl.fading) begin
          rem_r  <= q_num[NUM_W-1:IDX_W];
          nlow_r <= q_num[IDX_W-1:0];
          cnt_r  <= '0;
        end else begin
          weight_r <= W_ONE;
        end
      end
    end
    if (div_en) begin
      rem_r  <= rem_nxt;
      nlow_r <= nlow_r << 1;
      quo_r  <= {quo_r[IDX_W-2:0], rem_ge};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (rom_en) begin
      weight_r <= rom_w[quo_r];
    end
    if (mul_en) begin
      prod_r <= mul_full[ACC_W-1:0];
    end
    if (out_load) begin
      out_mixed_r  <= mixed;
      out_fading_r <= fading_r;
      out_end_r    <= last_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_mixed_r;
  assign out_fading       = out_fading_r;
  assign out_frame_end    = out_end_r;

endmodule

`default_nettype wire

// ===== rtl/raised_cosine_crossfader_core.sv =====
// Raised-cosine crossfader for interleaved multichannel audio.
// Input channel (in_valid / in_stall): one word per channel sample, carrying the
// old-chain sample, the new-chain sample and a start flag that restarts the fade
// when it arrives on the first channel of a frame. Output channel (out_valid /
// out_stall): the blended sample, the frame's fading bit and a frame-end marker.
// Configuration (cfg_we / cfg_index / cfg_wdata): index 0 is the fade length in
// frames (0 passes new samples through), index 1 the channel count; write only
// while no word is in flight.
// An accepted word passes the queue and the sequencer states idle, multiply and
// accumulate before out_valid. The first channel of a fading frame also passes
// the divide state, which yields the IDX_W-bit table index one quotient bit per
// cycle (IDX_W = log2 of the cosine table size, 10 by default), and the
// registered table read. The sequencer holds one word at a time.
// A two-word queue sits between the classifying front end and the sequencer,
// and the output register holds a result while the receiver stalls; the queue
// fills, then in_stall rises. Synchronous reset clears the frame position,
// channel slot, queue and output valid; the registers return to length 0 and
// two channels.
`default_nettype none

module raised_cosine_crossfader_core #(
  parameter int SAMPLE_BITS    = crf_pkg::SAMPLE_BITS_DEF,
  parameter int COS_TABLE_SIZE = crf_pkg::COS_TABLE_SIZE_DEF,
  parameter int MAX_CHANNELS   = crf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_old_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_new_sample,
  input  logic                              in_start_fade,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_mixed_sample,
  output logic                              out_fading,
  output logic                              out_frame_end,
  input  logic                              cfg_we,
  input  logic [crf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import crf_pkg::*;

  localparam int DATA_W = 2 * SAMPLE_BITS + LEN_W + $bits(crf_ctrl_t);

  logic [LEN_W-1:0]  fade_length_r;
  logic [CHAN_W-1:0] channel_count_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_length_r   <= '0;
      channel_count_r <= CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FADE_LENGTH:   fade_length_r   <= cfg_wdata[LEN_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  logic              push;
  logic [DATA_W-1:0] push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [DATA_W-1:0] q_data;

  crf_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_old_sample (in_old_sample),
    .in_new_sample (in_new_sample),
    .in_start_fade (in_start_fade),
    .fade_length   (fade_length_r),
    .channel_count (channel_count_r),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  crf_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (q_data)
  );

  crf_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COS_TABLE_SIZE (COS_TABLE_SIZE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .fade_length      (fade_length_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mixed_sample (out_mixed_sample),
    .out_fading       (out_fading),
    .out_frame_end    (out_frame_end)
  );

endmodule

`default_nettype wire

// ===== rtl/crf_checker.sv =====
`default_nettype none

`include "raised_cosine_crossfader_core_assert.svh"

module crf_checker #(
  parameter int SAMPLE_BITS = crf_pkg::SAMPLE_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [SAMPLE_BITS-1:0]     out_mixed_sample,
  input logic                              out_fading,
  input logic                              out_frame_end,
  input logic                              cfg_we,
  input logic [crf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [crf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import crf_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending_r;
  logic       mid_frame_r;
  logic       prev_fading_r;
  logic       len_zero_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Words in flight, frame tracking on the output side, last written length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= '0;
      mid_frame_r   <= 1'b0;
      prev_fading_r <= 1'b0;
      len_zero_r    <= 1'b1;
    end else begin
      if (in_acc && !out_acc) begin
        pending_r <= pending_r + 4'd1;
      end else if (out_acc && !in_acc) begin
        pending_r <= pending_r - 4'd1;
      end
      if (out_acc) begin
        mid_frame_r   <= !out_frame_end;
        prev_fading_r <= out_fading;
      end
      if (cfg_we && cfg_index == REG_FADE_LENGTH) begin
        len_zero_r <= (cfg_wdata[LEN_W-1:0] == '0);
      end
    end
  end

  // A held result stays put
  `CRF_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_mixed_sample) && $stable(out_fading) && $stable(out_frame_end))

  // No result without an accepted word behind it
  `CRF_ASSERT_IMP(a_no_spurious, out_valid, pending_r != 4'd0)

  // Fading bit is constant across a frame
  `CRF_ASSERT_IMP(a_frame_fading, out_valid && mid_frame_r, out_fading == prev_fading_r)

  // Zero fade length starts frames in pass-through
  `CRF_ASSERT_IMP(a_len_zero, out_valid && len_zero_r && !mid_frame_r, !out_fading)

endmodule

bind raised_cosine_crossfader_core crf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_crf_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crf_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int MAX_CH       = MAX_CHANNELS_DEF;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 105;

  typedef longint unsigned u64_t;

  localparam u64_t ROM_SIZE = u64_t'(COS_TABLE_SIZE_DEF);

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

  localparam logic signed [SB-1:0] S_MAX = 24'sd8388607;
  localparam logic signed [SB-1:0] S_MIN = -24'sd8388608;
  localparam logic signed [SB-1:0] ZERO  = '0;
  localparam logic PIN  = 1'b1;
  localparam logic FREE = 1'b0;

  // Random-phase settings: fade length and channel count per phase
  localparam int PHASE_LEN [PHASES]   = '{3, 40, 0, 1, 16777215, 12};
  localparam int PHASE_CHANS [PHASES] = '{2, 1, 8, 3, 6, 4};

  typedef struct {
    logic signed [SB-1:0] mixed;
    logic                 fading;
    logic                 frame_end;
  } crossfade_result_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_LEN,
    ROW_CHANS,
    ROW_BADREG
  } plan_kind_t;

  // a is the old sample or a register value; mix/fade/fend are used when pin is set
  typedef struct {
    plan_kind_t           kind;
    logic signed [SB-1:0] a;
    logic signed [SB-1:0] b;
    logic                 start;
    logic                 pin;
    logic signed [SB-1:0] mix;
    logic                 fade;
    logic                 fend;
  } plan_row_t;

  localparam int PLAN_ROWS = 34;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    // pass-through after reset, two channels
    '{ROW_WORD,   S_MIN,        S_MAX,         1'b0, PIN,  S_MAX,   1'b0, 1'b0},
    '{ROW_WORD,   S_MAX,        S_MIN,         1'b0, PIN,  S_MIN,   1'b0, 1'b1},
    '{ROW_WORD,   ZERO,         ZERO,          1'b1, PIN,  ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd123,     -24'sd1,       1'b0, PIN,  -24'sd1, 1'b0, 1'b1},
    // full fade of four frames, one channel
    '{ROW_CHANS,  24'sd1,       ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_LEN,    24'sd4,       ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_BADREG, 24'sh5A5A5A,  ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   S_MAX,        S_MIN,         1'b1, PIN,  S_MAX,   1'b1, 1'b1},
    '{ROW_WORD,   S_MIN,        S_MAX,         1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd1234567, -24'sd7654321, 1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   -24'sd1,      24'sd1,        1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd5,       -24'sd7,       1'b0, PIN,  -24'sd7, 1'b0, 1'b1},
    '{ROW_WORD,   S_MIN,        ZERO,          1'b1, PIN,  S_MIN,   1'b1, 1'b1},
    // count above the maximum, longest length, start flag off the first channel
    '{ROW_CHANS,  24'sd15,      ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_LEN,    24'shFFFFFF,  ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd1000,    24'sd2000,     1'b1, PIN,  24'sd1000, 1'b1, 1'b0},
    '{ROW_WORD,   S_MIN,        S_MAX,         1'b1, PIN,  S_MIN,   1'b1, 1'b0},
    // count dropped to zero mid-frame: frame ends on the next word
    '{ROW_CHANS,  ZERO,         ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd77,      24'sd99,       1'b0, PIN,  24'sd77, 1'b1, 1'b1},
    '{ROW_WORD,   24'sd4000000, -24'sd4000000, 1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   -24'sd3,      24'sd3,        1'b0, FREE, ZERO,    1'b0, 1'b0},
    // length lowered below the position: pass-through, position holds
    '{ROW_LEN,    24'sd2,       ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd3,       24'sd4,        1'b0, PIN,  24'sd4,  1'b0, 1'b1},
    '{ROW_WORD,   -24'sd9,      24'sd9,        1'b0, PIN,  24'sd9,  1'b0, 1'b1},
    // eight channels, one-frame fade
    '{ROW_CHANS,  24'sd8,       ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_LEN,    24'sd1,       ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd11,      24'sd22,       1'b1, PIN,  24'sd11, 1'b1, 1'b0},
    '{ROW_WORD,   S_MAX,        S_MIN,         1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sh2AAAAA,  24'sh555555,   1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   -24'sd42,     24'sd42,       1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   S_MIN,        S_MIN,         1'b1, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   S_MAX,        S_MAX,         1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   24'sd8,       -24'sd8,       1'b0, FREE, ZERO,    1'b0, 1'b0},
    '{ROW_WORD,   -24'sd1,      ZERO,          1'b0, FREE, ZERO,    1'b0, 1'b0}
  };

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic signed [SB-1:0]  in_old_sample    = '0;
  logic signed [SB-1:0]  in_new_sample    = '0;
  logic                  in_start_fade    = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic signed [SB-1:0]  out_mixed_sample;
  logic                  out_fading;
  logic                  out_frame_end;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;

  // Fixed expectation travelling with the word on the input channel
  logic                 pin_on     = 1'b0;
  logic signed [SB-1:0] pin_mixed  = '0;
  logic                 pin_fading = 1'b0;
  logic                 pin_end    = 1'b0;

  // Mirror of the block's registers and frame state
  logic [LEN_W-1:0]  fade_len     = '0;
  logic [CHAN_W-1:0] chan_setting = CHAN_RESET;
  logic [LEN_W-1:0]  fade_pos     = '0;
  int unsigned       slot         = 0;
  logic [W_W-1:0]    frame_w      = '0;
  logic              frame_fade   = 1'b0;

  crossfade_result_t due_mixes [$];
  crossfade_result_t next_mix;
  crossfade_result_t oldest_mix;

  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;
  bit hold_off_req = 1'b0;

  int errors        = 0;
  int words_in      = 0;
  int reg_writes    = 0;
  int results_seen  = 0;
  int fade_results  = 0;
  int frame_ends    = 0;
  int cycle_count   = 0;

  raised_cosine_crossfader_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_old_sample    (in_old_sample),
    .in_new_sample    (in_new_sample),
    .in_start_fade    (in_start_fade),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mixed_sample (out_mixed_sample),
    .out_fading       (out_fading),
    .out_frame_end    (out_frame_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sin^2 weight in Q1.16 for one cosine-table address, sine by Taylor series in Q30
  function automatic logic [W_W-1:0] raised_weight(input u64_t addr);
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    u64_t   s;
    u64_t   w;
    longint sum;
    int     k;
    x    = (HALF_PI_Q30 * addr) / ROM_SIZE;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 14; k++) begin
      term = (term * x2) >> 30;
      term = term / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = u64_t'(sum);
    if (s > (u64_t'(1) << 30)) begin
      s = u64_t'(1) << 30;
    end
    w = (s * s + (u64_t'(1) << 43)) >> 44;
    if (w > u64_t'(W_ONE)) begin
      w = u64_t'(W_ONE);
    end
    return w[W_W-1:0];
  endfunction

  // Blend one word and advance the frame state
  function automatic crossfade_result_t crossfade_word(input logic signed [SB-1:0] old_s,
                                                       input logic signed [SB-1:0] new_s,
                                                       input logic start);
    crossfade_result_t r;
    int unsigned       chans;
    longint            acc;
    logic              last;
    chans = chan_setting;
    if (chans == 0) begin
      chans = 1;
    end
    if (chans > MAX_CH) begin
      chans = MAX_CH;
    end
    // weight and fading bit latch on the first channel
    if (slot == 0) begin
      if (start) begin
        fade_pos = '0;
      end
      frame_fade = (fade_len != 0) && (fade_pos < fade_len);
      if (frame_fade) begin
        frame_w = raised_weight((u64_t'(fade_pos) * ROM_SIZE) / u64_t'(fade_len));
      end else begin
        frame_w = W_ONE;
      end
    end
    acc = longint'(old_s) * (longint'(W_ONE) - longint'(frame_w)) +
          longint'(new_s) * longint'(frame_w);
    acc = (acc + 32768) >>> W_FRAC;
    if (acc > longint'(S_MAX)) begin
      acc = longint'(S_MAX);
    end
    if (acc < longint'(S_MIN)) begin
      acc = longint'(S_MIN);
    end
    last        = (slot + 1 >= chans);
    r.mixed     = acc[SB-1:0];
    r.fading    = frame_fade;
    r.frame_end = last;
    if (last) begin
      slot = 0;
      if (fade_len != 0 && fade_pos < fade_len) begin
        fade_pos = fade_pos + 1'b1;
      end
    end else begin
      slot++;
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        return S_MAX;
      end
      1: begin
        return S_MIN;
      end
      2: begin
        return SB'(int'($urandom_range(0, 64)) - 32);
      end
      default: begin
        return SB'($urandom());
      end
    endcase
  endfunction

  // Track register writes and accepted words, queue the expected mix
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_FADE_LENGTH) begin
          fade_len = cfg_wdata[LEN_W-1:0];
        end else if (cfg_index == REG_CHANNEL_COUNT) begin
          chan_setting = cfg_wdata[CHAN_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        next_mix = crossfade_word(in_old_sample, in_new_sample, in_start_fade);
        if (pin_on) begin
          next_mix.mixed     = pin_mixed;
          next_mix.fading    = pin_fading;
          next_mix.frame_end = pin_end;
        end
        due_mixes.push_back(next_mix);
        words_in++;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_fading) begin
        fade_results++;
      end
      if (out_frame_end) begin
        frame_ends++;
      end
      if (due_mixes.size() == 0) begin
        $display("%0t: unexpected result: mixed %0d fading %0b frame_end %0b",
                 $time, out_mixed_sample, out_fading, out_frame_end);
        errors++;
      end else begin
        oldest_mix = due_mixes.pop_front();
        if (out_mixed_sample !== oldest_mix.mixed || out_fading !== oldest_mix.fading ||
            out_frame_end !== oldest_mix.frame_end) begin
          $display("%0t: mismatch: expected mixed %0d fading %0b frame_end %0b, got mixed %0d fading %0b frame_end %0b",
                   $time, oldest_mix.mixed, oldest_mix.fading, oldest_mix.frame_end,
                   out_mixed_sample, out_fading, out_frame_end);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= stalls_on && ($urandom_range(0, 99) < 30);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offer one word and wait until it is taken
  task automatic send_word(input logic signed [SB-1:0] old_s,
                           input logic signed [SB-1:0] new_s,
                           input logic start,
                           input logic pin,
                           input logic signed [SB-1:0] mix,
                           input logic fade,
                           input logic fend);
    while (gaps_on && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_old_sample <= old_s;
    in_new_sample <= new_s;
    in_start_fade <= start;
    pin_on        <= pin;
    pin_mixed     <= mix;
    pin_fading    <= fade;
    pin_end       <= fend;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected mix has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_mixes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // Main sequence: reset, directed plan, random phases
  initial begin
    int        p;
    int        n;
    plan_row_t row;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < PLAN_ROWS; n++) begin
      row = directed_plan[n];
      case (row.kind)
        ROW_WORD: begin
          send_word(row.a, row.b, row.start, row.pin, row.mix, row.fade, row.fend);
        end
        ROW_LEN: begin
          drain_results();
          write_reg(REG_FADE_LENGTH, row.a);
        end
        ROW_CHANS: begin
          drain_results();
          write_reg(REG_CHANNEL_COUNT, row.a);
        end
        default: begin
          drain_results();
          write_reg(REG_SPARE, row.a);
        end
      endcase
    end

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_FADE_LENGTH, CFG_DATA_W'(PHASE_LEN[p]));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(PHASE_CHANS[p]));
      end else begin
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(PHASE_CHANS[p]));
        write_reg(REG_FADE_LENGTH, CFG_DATA_W'(PHASE_LEN[p]));
      end
      // one phase runs back to back with no idling on either side
      gaps_on   = (p != 2);
      stalls_on = (p != 2);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 1 && n == 30) begin
          hold_off_req = 1'b1;
        end
        if (p == 3 && n == 50) begin
          drain_results();
        end
        send_word(pick_sample(), pick_sample(), $urandom_range(0, 99) < 3,
                  FREE, ZERO, 1'b0, 1'b0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d words across %0d register writes (fade lengths 0 to max, 0..15 channels)",
             words_in, reg_writes);
    $display("Checked %0d results: %0d inside a fade, %0d frame ends, %0d errors",
             results_seen, fade_results, frame_ends, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
